### rtl/tsws_pkg.sv
// Shared types and constants for the timed sample window store.
// Used by tsws_cell and timed_sample_window_store; no dependencies.
package tsws_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int TIME_BITS_DEF = 32;
  localparam int LUX_BITS_DEF  = 16;

  localparam int          WINDOW_W     = 16;
  localparam logic [15:0] WINDOW_RESET = 16'd600;

  // tuser codes on the request channel
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_REPLY
  } state_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic shift;  // cells below the tail take their upper neighbor
    logic load;   // the tail cell takes the feed entry
  } cell_ctrl_t;

endpackage

### rtl/tsws_cell.sv
// One storage cell of the sample row: holds a timestamp and a lux level.
// Depends on tsws_pkg for the control struct and default widths.
module tsws_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 10,
  parameter int TIME_BITS = tsws_pkg::TIME_BITS_DEF,
  parameter int LUX_BITS  = tsws_pkg::LUX_BITS_DEF
) (
  input  logic                 clk_i,
  input  tsws_pkg::cell_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]     tail_i,
  input  logic [TIME_BITS-1:0] nbr_stamp_i,
  input  logic [LUX_BITS-1:0]  nbr_level_i,
  input  logic [TIME_BITS-1:0] feed_stamp_i,
  input  logic [LUX_BITS-1:0]  feed_level_i,
  output logic [TIME_BITS-1:0] stamp_o,
  output logic [LUX_BITS-1:0]  level_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [TIME_BITS-1:0] stamp_q, stamp_d;
  logic [LUX_BITS-1:0]  level_q, level_d;

  always_comb begin
    stamp_d = stamp_q;
    level_d = level_q;
    if (ctrl_i.load && (tail_i == MY_IDX)) begin
      stamp_d = feed_stamp_i;
      level_d = feed_level_i;
    end else if (ctrl_i.shift && (MY_IDX < tail_i)) begin
      stamp_d = nbr_stamp_i;
      level_d = nbr_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    level_q <= level_d;
  end

  assign stamp_o = stamp_q;
  assign level_o = level_q;

endmodule

### rtl/timed_sample_window_store.sv
// Top level of the timed sample window store: sequencer, output register and
// the row of tsws_cell storage cells. Depends on tsws_pkg and tsws_cell.
//
// Usage:
//   Requests enter on the s_axis channel. tuser is the kind: 0 = sample,
//   1 = query by timestamp. Every request yields exactly one result on the
//   m_axis channel, in order.
//   Samples are kept oldest first in a row of cells that works as a queue:
//   cell 0 is the oldest entry. A valid sample rotates the queue once through
//   cell 0, dropping entries older than current_time - window (clamped at 0),
//   then appends it if item_time is not older; a full row drops the oldest.
//   A query rotates the queue once, catching the first matching timestamp.
//   An invalid sample goes straight to the reply; a query passes the rotation
//   first, a valid sample the rotation and the append. The rotation moves one
//   entry per cycle through cell 0, over the entries held at accept (at most
//   DEPTH). One request is in work at a time; the next is taken after its reply.
//   A finished result waits in the output register while the next request
//   is taken; a stalled receiver holds the result and, once the next one is
//   done, holds off further requests until it takes the waiting one.
//   The user writes the window register through cfg_we_i / cfg_wdata_i only
//   while idle; the block itself does not enforce this. Reset empties the
//   store, clears the recent lux and sets the window to 600.
module timed_sample_window_store #(
  parameter  int DEPTH       = tsws_pkg::DEPTH_DEF,
  parameter  int TIME_BITS   = tsws_pkg::TIME_BITS_DEF,
  parameter  int LUX_BITS    = tsws_pkg::LUX_BITS_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int IN_W        = 1 + LUX_BITS + 2 * TIME_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = 2 * LUX_BITS + CNT_W + 3,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsws_pkg::WINDOW_W-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // sample_valid, sample_lux, item_time, current_time (lowest bit up)
  input  logic [IN_TDATA_W-1:0]        s_axis_tdata,
  // kind
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // recent_lux, found, found_lux, store_empty, stored_count, dropped_full
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LUX_LO = 1;
  localparam int IT_LO  = LUX_LO + LUX_BITS;
  localparam int NOW_LO = IT_LO + TIME_BITS;

  // request fields
  logic                 in_valid;
  logic [LUX_BITS-1:0]  in_lux;
  logic [TIME_BITS-1:0] in_itime, in_now, window_ext, in_cutoff;

  assign in_valid   = s_axis_tdata[0];
  assign in_lux     = s_axis_tdata[IT_LO-1:LUX_LO];
  assign in_itime   = s_axis_tdata[NOW_LO-1:IT_LO];
  assign in_now     = s_axis_tdata[NOW_LO+TIME_BITS-1:NOW_LO];

  tsws_pkg::state_e state_q, state_d;

  logic [tsws_pkg::WINDOW_W-1:0] window_q;
  logic [LUX_BITS-1:0]  recent_q, recent_d;
  logic [CNT_W-1:0]     count_q, count_d, steps_q, steps_d;
  logic                 kind_q, kind_d;
  logic [LUX_BITS-1:0]  lux_q, lux_d, flux_q, flux_d;
  logic [TIME_BITS-1:0] itime_q, itime_d, cutoff_q, cutoff_d;
  logic                 found_q, found_d, dropped_q, dropped_d;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // cell row
  tsws_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]     tail;
  logic [TIME_BITS-1:0] feed_stamp;
  logic [LUX_BITS-1:0]  feed_level;
  logic [TIME_BITS-1:0] cell_stamp [DEPTH];
  logic [LUX_BITS-1:0]  cell_level [DEPTH];

  logic accept, head_keep, out_free;

  assign window_ext = TIME_BITS'(window_q);
  assign in_cutoff  = (in_now > window_ext) ? (in_now - window_ext) : '0;
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign head_keep  = cell_stamp[0] >= cutoff_q;
  assign out_free   = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == tsws_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    recent_d   = recent_q;
    count_d    = count_q;
    steps_d    = steps_q;
    kind_d     = kind_q;
    lux_d      = lux_q;
    itime_d    = itime_q;
    cutoff_d   = cutoff_q;
    found_d    = found_q;
    flux_d     = flux_q;
    dropped_d  = dropped_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    ctrl       = '0;
    tail       = '0;
    feed_stamp = cell_stamp[0];
    feed_level = cell_level[0];

    case (state_q)
      tsws_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d    = s_axis_tuser;
          lux_d     = in_lux;
          itime_d   = in_itime;
          cutoff_d  = in_cutoff;
          found_d   = 1'b0;
          flux_d    = '0;
          dropped_d = 1'b0;
          steps_d   = count_q;
          if (s_axis_tuser == tsws_pkg::KIND_SAMPLE && !in_valid) begin
            state_d = tsws_pkg::ST_REPLY;
          end else begin
            if (s_axis_tuser == tsws_pkg::KIND_SAMPLE) begin
              recent_d = in_lux;
            end
            if (count_q != '0) begin
              state_d = tsws_pkg::ST_SCAN;
            end else if (s_axis_tuser == tsws_pkg::KIND_SAMPLE) begin
              state_d = tsws_pkg::ST_APPEND;
            end else begin
              state_d = tsws_pkg::ST_REPLY;
            end
          end
        end
      end

      tsws_pkg::ST_SCAN: begin
        // pop cell 0, push it back at the tail of the queue
        ctrl.shift = 1'b1;
        ctrl.load  = 1'b1;
        tail       = IDX_W'(count_q - CNT_W'(1));
        if (kind_q == tsws_pkg::KIND_SAMPLE) begin
          if (!head_keep) begin
            count_d = count_q - CNT_W'(1);
          end
        end else if (!found_q && cell_stamp[0] == itime_q) begin
          found_d = 1'b1;
          flux_d  = cell_level[0];
        end
        steps_d = steps_q - CNT_W'(1);
        if (steps_q == CNT_W'(1)) begin
          state_d = (kind_q == tsws_pkg::KIND_SAMPLE) ? tsws_pkg::ST_APPEND
                                                      : tsws_pkg::ST_REPLY;
        end
      end

      tsws_pkg::ST_APPEND: begin
        feed_stamp = itime_q;
        feed_level = lux_q;
        if (itime_q >= cutoff_q) begin
          ctrl.load = 1'b1;
          if (count_q < CNT_W'(DEPTH)) begin
            tail    = count_q[IDX_W-1:0];
            count_d = count_q + CNT_W'(1);
          end else begin
            // full: oldest falls out of cell 0
            ctrl.shift = 1'b1;
            tail       = IDX_W'(DEPTH - 1);
            dropped_d  = 1'b1;
          end
        end
        state_d = tsws_pkg::ST_REPLY;
      end

      tsws_pkg::ST_REPLY: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_TDATA_W'({dropped_q, count_q, (count_q == '0), flux_q,
                                    found_q, recent_q});
          state_d   = tsws_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tsws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= tsws_pkg::WINDOW_RESET;
      recent_q  <= '0;
      count_q   <= '0;
      steps_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      recent_q  <= recent_d;
      count_q   <= count_d;
      steps_q   <= steps_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    lux_q     <= lux_d;
    itime_q   <= itime_d;
    cutoff_q  <= cutoff_d;
    found_q   <= found_d;
    flux_q    <= flux_d;
    dropped_q <= dropped_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TIME_BITS-1:0] nbr_stamp;
    logic [LUX_BITS-1:0]  nbr_level;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr_stamp = cell_stamp[i+1];
      assign nbr_level = cell_level[i+1];
    end else begin : g_end
      assign nbr_stamp = feed_stamp;
      assign nbr_level = feed_level;
    end

    tsws_cell #(
      .INDEX    (i),
      .IDX_W    (IDX_W),
      .TIME_BITS(TIME_BITS),
      .LUX_BITS (LUX_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .tail_i      (tail),
      .nbr_stamp_i (nbr_stamp),
      .nbr_level_i (nbr_level),
      .feed_stamp_i(feed_stamp),
      .feed_level_i(feed_level),
      .stamp_o     (cell_stamp[i]),
      .level_o     (cell_level[i])
    );
  end

  // fill level never passes the row length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill level beyond depth");

  // a drop for lack of room leaves the row full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsws_pkg::ST_REPLY && dropped_q) |-> count_q == CNT_W'(DEPTH))
    else $error("drop reported with room left");

  // only a query can report a match
  a_found_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsws_pkg::ST_REPLY && found_q) |-> kind_q == tsws_pkg::KIND_QUERY)
    else $error("match reported for a sample");

  // fill level moves only while the row is worked on
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsws_pkg::ST_IDLE || state_q == tsws_pkg::ST_REPLY) |=> $stable(count_q))
    else $error("fill level changed outside a pass");

endmodule

### tb/sv/tb_timed_sample_window_store.sv
// Self-checking testbench for timed_sample_window_store: directed table, a long
// fill, then randomized phases per window setting, scored against a local model where the table gives no result.
// Depends on tsws_pkg and the timed_sample_window_store RTL.
module tb_timed_sample_window_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = tsws_pkg::DEPTH_DEF;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;
  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 300;
  localparam int FILL_N      = 120;

  // packed from the lowest bit up: sample_valid, sample_lux, item_time, current_time
  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic [31:0] itime;
    logic [15:0] lux;
    logic        valid;
  } req_t;

  // same bit order as m_axis_tdata[45:0]
  typedef struct packed {
    logic        dropped_full;
    logic [10:0] stored_count;
    logic        store_empty;
    logic [15:0] found_lux;
    logic        found;
    logic [15:0] recent_lux;
  } result_t;

  typedef struct packed {
    req_t    req;
    logic    typed;
    result_t res;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] lux;
  } entry_t;

  localparam int DIR_ROWS = 18;
  // rows: '{kind, now, itime, lux, valid}, typed, '{dropped, count, empty, flux, found, recent}
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{'{tsws_pkg::KIND_QUERY,  32'd0, 32'd0, 16'h0000, 1'b0}, 1'b1,
      '{1'b0, 11'd0, 1'b1, 16'h0000, 1'b0, 16'h0000}},
    '{'{tsws_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0}, 1'b1,
      '{1'b0, 11'd0, 1'b1, 16'h0000, 1'b0, 16'h0000}},
    '{'{tsws_pkg::KIND_SAMPLE, 32'd100, 32'd100, 16'h1234, 1'b1}, 1'b1,
      '{1'b0, 11'd1, 1'b0, 16'h0000, 1'b0, 16'h1234}},
    '{'{tsws_pkg::KIND_QUERY,  32'd100, 32'd100, 16'h0000, 1'b0}, 1'b1,
      '{1'b0, 11'd1, 1'b0, 16'h1234, 1'b1, 16'h1234}},
    '{'{tsws_pkg::KIND_QUERY,  32'd100, 32'd101, 16'h0000, 1'b0}, 1'b1,
      '{1'b0, 11'd1, 1'b0, 16'h0000, 1'b0, 16'h1234}},
    '{'{tsws_pkg::KIND_SAMPLE, 32'd100, 32'd100, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{tsws_pkg::KIND_QUERY,  32'd100, 32'd100, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{tsws_pkg::KIND_SAMPLE, 32'd500, 32'd0, 16'h0000, 1'b1}, 1'b0, '0},
    '{'{tsws_pkg::KIND_QUERY,  32'd500, 32'd0, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{tsws_pkg::KIND_SAMPLE, 32'd1000, 32'd200, 16'h0100, 1'b1}, 1'b0, '0},
    '{'{tsws_pkg::KIND_QUERY,  32'd1000, 32'd200, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{tsws_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 1'b1}, 1'b0, '0},
    '{'{tsws_pkg::KIND_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{tsws_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 32'd1, 16'h5555, 1'b0}, 1'b0, '0},
    '{'{tsws_pkg::KIND_QUERY,  32'hFFFF_FFFF, 32'd0, 16'hABCD, 1'b1}, 1'b0, '0},
    '{'{tsws_pkg::KIND_SAMPLE, 32'd0, 32'd0, 16'hAAAA, 1'b1}, 1'b0, '0},
    '{'{tsws_pkg::KIND_QUERY,  32'd0, 32'd0, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{tsws_pkg::KIND_SAMPLE, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 1'b1}, 1'b0, '0}
  };

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic [tsws_pkg::WINDOW_W-1:0] cfg_wdata_i    = '0;
  logic                          s_axis_tvalid  = 1'b0;
  logic                          s_axis_tready;
  logic [IN_TDATA_W-1:0]         s_axis_tdata   = '0;
  logic                          s_axis_tuser   = tsws_pkg::KIND_SAMPLE;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0]        m_axis_tdata;

  // model state
  logic [15:0] win_len  = tsws_pkg::WINDOW_RESET;
  logic [15:0] last_lux = '0;
  entry_t      held_q[$];

  result_t pending_results[$];
  int      mismatch_cnt = 0;
  int      result_idx   = 0;
  int      stall_cycles = 0;
  int      rx_hold_len  = 0;
  bit      tx_gaps_on   = 1'b1;
  bit      rx_gaps_on   = 1'b1;

  timed_sample_window_store u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // updates the window model with one request and returns its result
  function automatic result_t predict_window(input req_t r);
    result_t     res;
    logic [31:0] cutoff;
    entry_t      kept[$];
    entry_t      e;
    res = '0;
    if (r.kind == tsws_pkg::KIND_SAMPLE) begin
      if (r.valid) begin
        cutoff = (r.now > {16'h0, win_len}) ? r.now - {16'h0, win_len} : 32'd0;
        last_lux = r.lux;
        foreach (held_q[i]) begin
          if (held_q[i].stamp >= cutoff) kept.push_back(held_q[i]);
        end
        held_q = kept;
        if (r.itime >= cutoff) begin
          if (held_q.size() >= DEPTH) begin
            void'(held_q.pop_front());
            res.dropped_full = 1'b1;
          end
          e.stamp = r.itime;
          e.lux   = r.lux;
          held_q.push_back(e);
        end
      end
    end else begin
      for (int i = 0; i < held_q.size(); i++) begin
        if (held_q[i].stamp == r.itime) begin
          res.found     = 1'b1;
          res.found_lux = held_q[i].lux;
          break;
        end
      end
    end
    res.recent_lux   = last_lux;
    res.store_empty  = (held_q.size() == 0);
    res.stored_count = 11'(held_q.size());
    return res;
  endfunction

  // offers one request and waits for the block to take it
  task automatic send_req(input req_t r, input logic typed, input result_t typed_res);
    int      gap;
    bit      hs;
    result_t pred;
    gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, r.now, r.itime, r.lux, r.valid};
    s_axis_tuser  <= r.kind;
    hs = 1'b0;
    while (!hs) begin
      @(negedge clk_i);
      hs = s_axis_tready;
      @(posedge clk_i);
    end
    pred = predict_window(r);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [15:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_len = value;
  endtask

  // long run of samples with a window that keeps everything, then probe the store
  task automatic fill_store();
    req_t r;
    set_window(16'hFFFF);
    for (int k = 0; k < FILL_N; k++) begin
      r.kind  = tsws_pkg::KIND_SAMPLE;
      r.valid = 1'b1;
      r.lux   = 16'($urandom_range(0, 65535));
      r.itime = 32'(k);
      r.now   = 32'd2000;
      send_req(r, 1'b0, '0);
    end
    r.kind = tsws_pkg::KIND_QUERY;
    r.itime = 32'd5;
    send_req(r, 1'b0, '0);
    r.itime = 32'(FILL_N - 1);
    send_req(r, 1'b0, '0);
    r.itime = 32'(FILL_N + 5);
    send_req(r, 1'b0, '0);
    // age eviction drops the oldest stamps before the append
    r.kind  = tsws_pkg::KIND_SAMPLE;
    r.itime = 32'd70000;
    r.now   = 32'd65543;
    send_req(r, 1'b0, '0);
    r.itime = 32'd70001;
    send_req(r, 1'b0, '0);
  endtask

  task automatic run_phase(input logic [15:0] win, input logic [31:0] start, input int n,
                           input bit tx_gap, input bit rx_gap, input bit squeeze);
    req_t        r;
    logic [31:0] now_t;
    int          pick;
    int          burst;
    set_window(win);
    tx_gaps_on = tx_gap;
    rx_gaps_on = rx_gap;
    now_t = start;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (i == n / 4) drain_results();
      if (squeeze && i == n / 2) begin
        rx_hold_len = HOLD_CYCLES;
        tx_gaps_on = 1'b0;
        burst = 10;
      end
      if (burst > 0) begin
        burst--;
        if (burst == 0) tx_gaps_on = tx_gap;
      end
      now_t += 32'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      r.kind  = tsws_pkg::KIND_SAMPLE;
      r.valid = 1'b1;
      r.lux   = 16'($urandom_range(0, 65535));
      r.now   = now_t;
      if (pick < 6) begin
        r.kind  = logic'($urandom_range(0, 1));
        r.valid = logic'($urandom_range(0, 1));
        r.itime = $urandom;
        r.now   = $urandom;
      end else if (pick < 16) begin
        r.valid = 1'b0;
        r.itime = $urandom;
      end else if (pick < 22) begin
        r.itime = now_t + 32'($urandom_range(0, 5));
      end else if (pick < 58) begin
        r.itime = now_t - 32'($urandom_range(0, int'(win) + 4));
      end else begin
        r.kind  = tsws_pkg::KIND_QUERY;
        r.valid = logic'($urandom_range(0, 1));
        if (held_q.size() != 0 && $urandom_range(0, 9) < 7)
          r.itime = held_q[$urandom_range(0, held_q.size() - 1)].stamp;
        else
          r.itime = now_t - 32'($urandom_range(0, 40));
      end
      send_req(r, 1'b0, '0);
    end
  endtask

  // result side: random backpressure plus a long hold-off on request
  initial begin : result_sink
    int      gap;
    bit      hs;
    result_t got;
    result_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_gaps_on ? $urandom_range(0, 5) : 0;
      if (rx_hold_len > 0) begin
        gap += rx_hold_len;
        rx_hold_len = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      hs = 1'b0;
      while (!hs) begin
        @(negedge clk_i);
        hs  = m_axis_tvalid;
        got = result_t'(m_axis_tdata[45:0]);
        @(posedge clk_i);
      end
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result %0d: no result expected, got %p", result_idx, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected %p, got %p", result_idx, want, got);
        end
      end
      result_idx++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].res);

    fill_store();

    // window of zero: the cutoff is the present time
    run_phase(16'd0,     32'h0000_0040, 45, 1'b1, 1'b1, 1'b0);
    run_phase(16'd1,     $urandom,      50, 1'b0, 1'b0, 1'b0);
    run_phase(16'd30,    32'hFFFF_FF80, 55, 1'b1, 1'b0, 1'b1);
    run_phase(16'd600,   $urandom,      55, 1'b0, 1'b1, 1'b0);
    run_phase(16'hFFFF,  32'd100,       55, 1'b1, 1'b1, 1'b1);
    run_phase(16'd7,     $urandom,      50, 1'b1, 1'b1, 1'b0);

    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
